>>> sv/qmf_polyphase_analysis_defines.svh
// ----------------------------------------------------------------------------
// QMF analysis assertion macros
// Shared assertion forms for the QMF analysis bank, clocked on clk and held
// off during reset.
// ----------------------------------------------------------------------------
`ifndef QMF_POLYPHASE_ANALYSIS_DEFINES_SVH
`define QMF_POLYPHASE_ANALYSIS_DEFINES_SVH
// Same-cycle implication.
`define QMF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qmf assertion failed");
// Next-cycle implication.
`define QMF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qmf assertion failed");
`endif

>>> sv/qmf_pkg.sv
// ----------------------------------------------------------------------------
// QMF analysis package
// Widths, request codes and the lane control bundle shared by the bank.
// ----------------------------------------------------------------------------
package qmf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 11;
  localparam int ACC_W      = 31;
  localparam int PACK_SHIFT = 15;
  localparam int LANES      = 4;

  localparam logic [CFG_W-1:0] BLOCK_PAIRS_RESET = 11'd256;

  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
  } lane_ctl_t;

endpackage

>>> sv/qmf_polyphase_analysis.sv
// ----------------------------------------------------------------------------
// Two-band polyphase QMF analysis bank
// Four MAC lanes (left/right of each phase) feed a merge stage that forms
// the low and high stereo bands; a sequencer runs taps and block tails.
// ----------------------------------------------------------------------------
// A coefficient item is taken without leaving S_IDLE, so the next item can
// be taken straight after it. A sample item steps the four lanes one tap
// per cycle through the pair window in S_MAC, then passes S_DRAIN and waits in
// S_RES for the output register to free. The item that ends a block is
// followed by the overlap tail pass, an S_TMAC, S_TDRAIN and S_TWR round for
// each k below FILTER_TAPS/2 - 1, before the next item is taken.
// Reset clears taps, window and history at once.
module qmf_polyphase_analysis #(
  parameter int FILTER_TAPS     = 32,
  parameter int MAX_BLOCK_PAIRS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_block_pairs,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [4:0]  in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic signed [15:0] in_even_left,
  input  logic signed [15:0] in_even_right,
  input  logic signed [15:0] in_odd_left,
  input  logic signed [15:0] in_odd_right,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_low_left,
  output logic signed [15:0] out_low_right,
  output logic signed [15:0] out_high_left,
  output logic signed [15:0] out_high_right,
  output logic        out_block_last
);

  `include "qmf_polyphase_analysis_defines.svh"

  localparam int HALF = FILTER_TAPS / 2;
  localparam int HIST = HALF - 1;
  localparam int JW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int KW   = (HIST > 1) ? $clog2(HIST) : 1;
  localparam int PW   = $clog2(MAX_BLOCK_PAIRS);
  localparam int LW   = PW + 1;
  localparam int CW   = ((LW > qmf_pkg::CFG_W) ? LW : qmf_pkg::CFG_W) + 1;
  localparam int SW   = qmf_pkg::SAMPLE_W;
  localparam int WW   = qmf_pkg::LANES * SW;

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_DRAIN, S_RES, S_TMAC, S_TDRAIN, S_TWR
  } state_t;

  state_t state_r;
  logic [JW-1:0] j_r;
  logic [KW-1:0] k_r;
  logic [PW-1:0] pos_r;
  logic [qmf_pkg::CFG_W-1:0] block_pairs_r;

  qmf_pkg::sample_t tap_odd_r  [HALF];
  qmf_pkg::sample_t tap_even_r [HALF];
  logic [WW-1:0] window_r [HALF];
  logic [WW-1:0] hist_r   [HIST];

  logic sample_acc, coef_acc;
  logic [JW-1:0] shift_w, widx;
  logic [WW-1:0] win_rd, hist_rd;
  logic [CW-1:0] bp_ext, len_w, pos_inc;
  logic last_w, free, load;
  logic tail_done;
  qmf_pkg::lane_ctl_t ctl;
  logic [qmf_pkg::LANES-1:0][SW-1:0] packs, hist_v;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign sample_acc = in_valid && in_ready && (in_req_type == qmf_pkg::REQ_SAMPLE);
  assign coef_acc   = in_valid && in_ready && (in_req_type == qmf_pkg::REQ_COEF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_pairs_r <= qmf_pkg::BLOCK_PAIRS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      block_pairs_r <= cfg_block_pairs;
    end
  end

  // Taps split by parity so each lane reads its table at the tap step alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HALF; i++) begin
        tap_odd_r[i]  <= '0;
        tap_even_r[i] <= '0;
      end
    end else if (coef_acc && (int'(in_coef_index) < FILTER_TAPS)) begin
      for (int i = 0; i < HALF; i++) begin
        if (int'(in_coef_index[4:1]) == i) begin
          if (in_coef_index[0]) begin
            tap_odd_r[i] <= in_coef_value;
          end else begin
            tap_even_r[i] <= in_coef_value;
          end
        end
      end
    end
  end

  assign tail_done = (state_r == S_TWR) && (k_r == KW'(HIST - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HALF; i++) window_r[i] <= '0;
    end else if (sample_acc) begin
      window_r[0] <= {in_odd_right, in_odd_left, in_even_right, in_even_left};
      for (int i = 1; i < HALF; i++) window_r[i] <= window_r[i-1];
    end else if (tail_done) begin
      for (int i = 0; i < HALF; i++) window_r[i] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST; i++) hist_r[i] <= '0;
    end else if (state_r == S_TWR) begin
      hist_r[k_r] <= packs;
    end
  end

  // Tail passes read the window one pair behind per history entry.
  assign shift_w = (state_r == S_TMAC) ? (JW'(k_r) + JW'(1)) : '0;
  assign widx    = j_r - shift_w;
  assign win_rd  = window_r[widx];
  assign hist_rd = (int'(pos_r) < HIST) ? hist_r[KW'(pos_r)] : '0;

  always_comb begin
    for (int c = 0; c < qmf_pkg::LANES; c++) begin
      hist_v[c] = hist_rd[c*SW +: SW];
    end
  end

  assign bp_ext  = CW'(block_pairs_r);
  assign len_w   = (bp_ext < CW'(HALF)) ? CW'(HALF) :
                   (bp_ext > CW'(MAX_BLOCK_PAIRS)) ? CW'(MAX_BLOCK_PAIRS) : bp_ext;
  assign pos_inc = CW'(pos_r) + CW'(1);
  assign last_w  = (pos_inc >= len_w);
  assign load    = (state_r == S_RES) && free;

  assign ctl.mul_en = (state_r == S_MAC) || (state_r == S_TMAC);
  assign ctl.clr    = sample_acc || (load && last_w) || (state_r == S_TWR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
      k_r     <= '0;
      pos_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (sample_acc) begin
            j_r     <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          j_r <= j_r + JW'(1);
          if (j_r == JW'(HALF - 1)) state_r <= S_DRAIN;
        end
        S_DRAIN: state_r <= S_RES;
        S_RES: begin
          if (free) begin
            if (last_w) begin
              k_r     <= '0;
              j_r     <= JW'(1);
              state_r <= S_TMAC;
            end else begin
              pos_r   <= pos_r + PW'(1);
              state_r <= S_IDLE;
            end
          end
        end
        S_TMAC: begin
          j_r <= j_r + JW'(1);
          if (j_r == JW'(HALF - 1)) state_r <= S_TDRAIN;
        end
        S_TDRAIN: state_r <= S_TWR;
        S_TWR: begin
          if (tail_done) begin
            pos_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + KW'(1);
            j_r     <= JW'(k_r) + JW'(2);
            state_r <= S_TMAC;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  qmf_lane u_lane_p0l (
    .clk, .rst_n, .ctl, .tap(tap_odd_r[j_r]), .sample(win_rd[0*SW +: SW]),
    .pack(packs[0])
  );
  qmf_lane u_lane_p0r (
    .clk, .rst_n, .ctl, .tap(tap_odd_r[j_r]), .sample(win_rd[1*SW +: SW]),
    .pack(packs[1])
  );
  qmf_lane u_lane_p1l (
    .clk, .rst_n, .ctl, .tap(tap_even_r[j_r]), .sample(win_rd[2*SW +: SW]),
    .pack(packs[2])
  );
  qmf_lane u_lane_p1r (
    .clk, .rst_n, .ctl, .tap(tap_even_r[j_r]), .sample(win_rd[3*SW +: SW]),
    .pack(packs[3])
  );

  qmf_merge u_merge (
    .clk, .rst_n, .load, .packs, .hist(hist_v), .last(last_w), .free,
    .out_valid, .out_ready, .out_low_left, .out_low_right,
    .out_high_left, .out_high_right, .out_block_last
  );

  `QMF_ASSERT_NXT(a_sample_starts_mac, sample_acc, state_r == S_MAC)
  `QMF_ASSERT_NXT(a_tail_rewinds, tail_done, (pos_r == '0) && (state_r == S_IDLE))
  `QMF_ASSERT_IMP(a_out_from_result, $rose(out_valid), $past(state_r) == S_RES)

endmodule

>>> sv/qmf_lane.sv
// ----------------------------------------------------------------------------
// QMF MAC lane
// One channel's multiply-accumulate: registered product, then a wrapping
// accumulator whose bits 30..15 form the packed phase value.
// ----------------------------------------------------------------------------
module qmf_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  qmf_pkg::lane_ctl_t  ctl,
  input  qmf_pkg::sample_t    tap,
  input  qmf_pkg::sample_t    sample,
  output logic [qmf_pkg::SAMPLE_W-1:0] pack
);

  logic signed [2*qmf_pkg::SAMPLE_W-1:0] prod_r;
  logic                                  prod_v_r;
  logic [qmf_pkg::ACC_W-1:0]             acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= tap * sample;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + prod_r[qmf_pkg::ACC_W-1:0];
    end
  end

  assign pack = acc_r[qmf_pkg::PACK_SHIFT +: qmf_pkg::SAMPLE_W];

endmodule

>>> sv/qmf_merge.sv
// ----------------------------------------------------------------------------
// QMF band merge
// Adds the overlap history to each lane's phase value, forms the sum and
// difference bands and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module qmf_merge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [qmf_pkg::LANES-1:0][qmf_pkg::SAMPLE_W-1:0] packs,
  input  logic [qmf_pkg::LANES-1:0][qmf_pkg::SAMPLE_W-1:0] hist,
  input  logic        last,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_low_left,
  output logic signed [15:0] out_low_right,
  output logic signed [15:0] out_high_left,
  output logic signed [15:0] out_high_right,
  output logic        out_block_last
);

  logic [qmf_pkg::LANES-1:0][qmf_pkg::SAMPLE_W-1:0] ph;
  logic out_valid_r;
  logic [15:0] low_l_r, low_r_r, high_l_r, high_r_r;
  logic last_r;

  always_comb begin
    for (int c = 0; c < qmf_pkg::LANES; c++) begin
      ph[c] = packs[c] + hist[c];
    end
  end

  assign free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      low_l_r  <= ph[0] + ph[2];
      low_r_r  <= ph[1] + ph[3];
      high_l_r <= ph[0] - ph[2];
      high_r_r <= ph[1] - ph[3];
      last_r   <= last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_low_left   = low_l_r;
  assign out_low_right  = low_r_r;
  assign out_high_left  = high_l_r;
  assign out_high_right = high_r_r;
  assign out_block_last = last_r;

endmodule
